/* src/bst_pkg.sv */
// Package for the boosted stump trainer: field widths, operation and register codes,
// payload structs, the 2^-x fraction table and default sizes.
// No dependencies.
package bst_pkg;

  localparam int MAX_SAMPLES_DEF  = 1024;
  localparam int NUM_FEATURES_DEF = 16;
  localparam int NUM_CLASS_DEF    = 7;

  localparam int OP_W       = 2;
  localparam int SIDX_W     = 10;
  localparam int FIDX_W     = 4;
  localparam int VAL_W      = 32;
  localparam int LAB_W      = 3;
  localparam int CLS_OUT_W  = 3;
  localparam int FEAT_OUT_W = 4;
  localparam int CFG_IDX_W  = 2;

  localparam logic [OP_W-1:0] OP_FEATURE = 2'd0;
  localparam logic [OP_W-1:0] OP_LABEL   = 2'd1;
  localparam logic [OP_W-1:0] OP_ROUND   = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_LAMBDA   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLES  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FEATURES = 2'd2;

  localparam logic [31:0] LAMBDA_RST   = 32'h0001_0000;
  localparam logic [10:0] SAMPLES_RST  = 11'd1;
  localparam logic [4:0]  FEATURES_RST = 5'd16;

  localparam logic [16:0] Q_ONE     = 17'h1_0000;
  localparam logic [16:0] LOG2E_Q16 = 17'd94548;

  typedef struct packed {
    logic [OP_W-1:0]          operation;
    logic [SIDX_W-1:0]        sample_index;
    logic [FIDX_W-1:0]        feature_index;
    logic signed [VAL_W-1:0]  feature_value;
    logic [LAB_W-1:0]         class_label;
  } in_item_t;

  typedef struct packed {
    logic [CLS_OUT_W-1:0]     class_index;
    logic [FEAT_OUT_W-1:0]    split_feature;
    logic signed [VAL_W-1:0]  split_threshold;
    logic signed [VAL_W-1:0]  split_gain;
    logic signed [VAL_W-1:0]  left_leaf_weight;
    logic signed [VAL_W-1:0]  right_leaf_weight;
    logic                     last;
  } out_item_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0] index;
    logic [31:0]          value;
  } cfg_item_t;

  // 2^(-i/16) in Q1.16, i = 0..16
  function automatic logic [16:0] pow2_frac(input logic [4:0] idx);
    logic [16:0] r;
    case (idx)
      5'd0:    r = 17'd65536;
      5'd1:    r = 17'd62757;
      5'd2:    r = 17'd60097;
      5'd3:    r = 17'd57549;
      5'd4:    r = 17'd55109;
      5'd5:    r = 17'd52773;
      5'd6:    r = 17'd50535;
      5'd7:    r = 17'd48393;
      5'd8:    r = 17'd46341;
      5'd9:    r = 17'd44376;
      5'd10:   r = 17'd42495;
      5'd11:   r = 17'd40693;
      5'd12:   r = 17'd38968;
      5'd13:   r = 17'd37316;
      5'd14:   r = 17'd35734;
      5'd15:   r = 17'd34219;
      default: r = 17'd32768;
    endcase
    return r;
  endfunction

endpackage

/* src/bst_chan_if.sv */
// Valid/ready channel carrying one payload struct per transfer.
// Payload types come from bst_pkg.
interface bst_chan_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* src/boosted_stump_trainer.sv */
// Boosted stump trainer top level: sample stores, softmax gradient pass, split search
// and score update around one shared restoring divider. Uses bst_pkg and bst_chan_if.
//
// One item at a time. A label write clears the sample's score row one class per cycle
// (a sample's scores are only defined once its label has been written, so rounds must use
// labeled samples only). A round item is long and set by the single divider, which forms an
// NW-bit quotient, NW = 2*(clog2(MAX_SAMPLES+1) + 16) (54 by default), and by the single-port
// stores, whose reads are registered: gradients are formed per sample and class; each of the
// nf*n candidate thresholds scans all n samples and forms a term per class and side; the leaf
// weights and the score update follow, and the NUM_CLASS results follow as fast as the sink
// takes them. The search term in nf*n^2 dominates.
module boosted_stump_trainer #(
  parameter int MAX_SAMPLES  = bst_pkg::MAX_SAMPLES_DEF,
  parameter int NUM_FEATURES = bst_pkg::NUM_FEATURES_DEF,
  parameter int NUM_CLASS    = bst_pkg::NUM_CLASS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  bst_chan_if.sink   in_i,
  bst_chan_if.source out_o,
  bst_chan_if.sink   cfg_i
);

  localparam int SAMP_W  = $clog2(MAX_SAMPLES);
  localparam int CNT_W   = $clog2(MAX_SAMPLES + 1);
  localparam int FEAT_W  = (NUM_FEATURES > 1) ? $clog2(NUM_FEATURES) : 1;
  localparam int NF_W    = $clog2(NUM_FEATURES + 1);
  localparam int CLS_W   = $clog2(NUM_CLASS);
  localparam int MW      = CNT_W + 16;
  localparam int GSW     = MW + 1;
  localparam int DW      = ((MW > 32) ? MW : 32) + 1;
  localparam int NW      = 2 * MW;
  localparam int DC_W    = $clog2(NW);
  localparam int GNW     = NW + 6;
  localparam int SUM_W   = CLS_W + 17;
  localparam int FDEPTH  = MAX_SAMPLES << FEAT_W;
  localparam int CDEPTH  = MAX_SAMPLES << CLS_W;
  localparam int GH_W    = 34;

  localparam logic signed [NW:0]  WMAX = (NW+1)'(32'sh7FFF_FFFF);
  localparam logic signed [NW:0]  WMIN = (NW+1)'(32'sh8000_0000);
  localparam logic signed [GNW-1:0] GMAX = GNW'(32'sh7FFF_FFFF);
  localparam logic signed [GNW-1:0] GMIN = GNW'(32'sh8000_0000);

  localparam logic [4:0] ST_IDLE   = 5'd0;
  localparam logic [4:0] ST_CLR    = 5'd1;
  localparam logic [4:0] ST_GA_ISS = 5'd2;
  localparam logic [4:0] ST_GA_CAP = 5'd3;
  localparam logic [4:0] ST_EX1    = 5'd4;
  localparam logic [4:0] ST_EX2    = 5'd5;
  localparam logic [4:0] ST_PDIV   = 5'd6;
  localparam logic [4:0] ST_DIV    = 5'd7;
  localparam logic [4:0] ST_GH     = 5'd8;
  localparam logic [4:0] ST_TG_SET = 5'd9;
  localparam logic [4:0] ST_TG_ACC = 5'd10;
  localparam logic [4:0] ST_TERM   = 5'd11;
  localparam logic [4:0] ST_CT_ISS = 5'd12;
  localparam logic [4:0] ST_CT_CAP = 5'd13;
  localparam logic [4:0] ST_CJ_ISS = 5'd14;
  localparam logic [4:0] ST_CJ_CAP = 5'd15;
  localparam logic [4:0] ST_CG_ISS = 5'd16;
  localparam logic [4:0] ST_CG_CAP = 5'd17;
  localparam logic [4:0] ST_CS_SET = 5'd18;
  localparam logic [4:0] ST_CS_ACC = 5'd19;
  localparam logic [4:0] ST_CMP    = 5'd20;
  localparam logic [4:0] ST_W_SET  = 5'd21;
  localparam logic [4:0] ST_W_ACC  = 5'd22;
  localparam logic [4:0] ST_U_FRD  = 5'd23;
  localparam logic [4:0] ST_U_FCAP = 5'd24;
  localparam logic [4:0] ST_U_SISS = 5'd25;
  localparam logic [4:0] ST_U_SCAP = 5'd26;
  localparam logic [4:0] ST_OUT    = 5'd27;

  // control and configuration
  logic [4:0]        state_q, ret_q;
  logic [CLS_W-1:0]  cls_q;
  logic [SAMP_W-1:0] j_q, i_q;
  logic [FEAT_W-1:0] f_q, best_f_q;
  logic              side_q, leaf_q, best_valid_q, go_left_q;
  logic [CNT_W-1:0]  n_q;
  logic [NF_W-1:0]   nf_q;
  logic [31:0]       lambda_q;
  logic [10:0]       samples_q;
  logic [4:0]        features_q;

  // datapath scalars
  logic signed [31:0]    m_q, thr_q, best_thr_q;
  logic [33:0]           y_q;
  logic [SUM_W-1:0]      sum_q;
  logic [NW-1:0]         quo_q;
  logic [DW-1:0]         rem_q, den_q;
  logic [DC_W-1:0]       dcnt_q;
  logic signed [GSW-1:0] term_g_q;
  logic [MW-1:0]         term_h_q;
  logic signed [GNW-1:0] tot_gain_q, gain_q, best_gain_q;

  // per-class registers
  logic signed [31:0]    s_q    [NUM_CLASS];
  logic [16:0]           e_q    [NUM_CLASS];
  logic signed [GSW-1:0] tot_g_q[NUM_CLASS];
  logic [MW-1:0]         tot_h_q[NUM_CLASS];
  logic signed [GSW-1:0] lg_q   [NUM_CLASS];
  logic [MW-1:0]         lh_q   [NUM_CLASS];
  logic signed [GSW-1:0] bl_g_q [NUM_CLASS];
  logic [MW-1:0]         bl_h_q [NUM_CLASS];
  logic signed [31:0]    wl_q   [NUM_CLASS];
  logic signed [31:0]    wr_q   [NUM_CLASS];

  // stores
  logic signed [31:0] feat_mem [FDEPTH];
  logic signed [31:0] sc_mem   [CDEPTH];
  logic [GH_W-1:0]    gh_mem   [CDEPTH];
  logic [2:0]         lab_mem  [MAX_SAMPLES];
  logic signed [31:0] feat_rd_q, sc_rd_q;
  logic [GH_W-1:0]    gh_rd_q;
  logic [2:0]         lab_rd_q;

  bst_pkg::in_item_t  in_d;
  bst_pkg::cfg_item_t cfg_d;
  logic in_acc, cfg_acc, in_si_ok, in_fi_ok;
  logic cls_last, j_last, i_last, f_last;
  logic [SAMP_W+FEAT_W-1:0] feat_ra, feat_wa;
  logic [SAMP_W+CLS_W-1:0]  row_a;
  logic                     sc_we;
  logic signed [31:0]       sc_wd;
  logic [CNT_W-1:0]         n_clamp;
  logic [NF_W-1:0]          nf_clamp;

  // exp and gradient datapath
  logic [32:0]        ex_diff;
  logic [49:0]        ex_prod;
  logic [17:0]        ex_k;
  logic [16:0]        ex_t0, ex_t1, ex_v, ex_e;
  logic [28:0]        ex_dp;
  logic [16:0]        p_val;
  logic [33:0]        h_prod;
  logic signed [17:0] grad_val;
  logic [15:0]        hess_val;
  logic signed [17:0] gh_g;
  logic [15:0]        gh_h;

  // divider and terms
  logic [DW:0]           div_sh;
  logic                  div_bit;
  logic [MW-1:0]         t_mag;
  logic [DW-1:0]         t_den;
  logic signed [GNW-1:0] quo_s;
  logic signed [NW:0]    w_full;
  logic signed [31:0]    w_sat, gain_sat, sc_w;
  logic signed [32:0]    sc_sum;
  logic signed [GSW-1:0] sel_g;
  logic [MW-1:0]         sel_h;

  assign in_d     = in_i.data;
  assign cfg_d    = cfg_i.data;
  assign in_i.ready  = (state_q == ST_IDLE);
  assign cfg_i.ready = 1'b1;
  assign in_acc   = in_i.valid & in_i.ready;
  assign cfg_acc  = cfg_i.valid & cfg_i.ready;
  assign in_si_ok = 32'(in_d.sample_index) < MAX_SAMPLES;
  assign in_fi_ok = 32'(in_d.feature_index) < NUM_FEATURES;

  assign cls_last = (cls_q == CLS_W'(NUM_CLASS - 1));
  assign j_last   = (CNT_W'(j_q) == n_q - CNT_W'(1));
  assign i_last   = (CNT_W'(i_q) == n_q - CNT_W'(1));
  assign f_last   = (NF_W'(f_q) == nf_q - NF_W'(1));

  assign n_clamp  = (samples_q == '0) ? CNT_W'(1) :
                    (32'(samples_q) > MAX_SAMPLES) ? CNT_W'(MAX_SAMPLES) : CNT_W'(samples_q);
  assign nf_clamp = (features_q == '0) ? NF_W'(1) :
                    (32'(features_q) > NUM_FEATURES) ? NF_W'(NUM_FEATURES) : NF_W'(features_q);

  assign row_a   = {j_q, cls_q};
  assign feat_wa = {SAMP_W'(in_d.sample_index), FEAT_W'(in_d.feature_index)};

  always_comb begin
    unique case (state_q)
      ST_CT_ISS: feat_ra = {i_q, f_q};
      ST_U_FRD:  feat_ra = {j_q, best_f_q};
      default:   feat_ra = {j_q, f_q};
    endcase
  end

  // exp(-(m - s)) as 2^-y with a linearly interpolated fraction table
  assign ex_diff = 33'($signed({m_q[31], m_q}) - $signed({s_q[cls_q][31], s_q[cls_q]}));
  assign ex_prod = ex_diff * LOG2E_Q16_50;
  localparam logic [49:0] LOG2E_Q16_50 = 50'(bst_pkg::LOG2E_Q16);
  assign ex_k  = y_q[33:16];
  assign ex_t0 = bst_pkg::pow2_frac({1'b0, y_q[15:12]});
  assign ex_t1 = bst_pkg::pow2_frac({1'b0, y_q[15:12]} + 5'd1);
  assign ex_dp = (ex_t0 - ex_t1) * y_q[11:0];
  assign ex_v  = ex_t0 - ex_dp[28:12];
  assign ex_e  = (ex_k >= 18'd31) ? 17'd0 : (ex_v >> ex_k[4:0]);

  assign p_val    = quo_q[16:0];
  assign grad_val = $signed({1'b0, p_val}) -
                    ((32'(lab_rd_q) == 32'(cls_q)) ? 18'sh1_0000 : 18'sh0);
  assign h_prod   = p_val * (bst_pkg::Q_ONE - p_val);
  assign hess_val = h_prod[31:16];

  assign gh_g = $signed(gh_rd_q[33:16]);
  assign gh_h = gh_rd_q[15:0];

  // restoring divider step
  assign div_sh  = {rem_q, quo_q[NW-1]};
  assign div_bit = (div_sh >= {1'b0, den_q});

  assign t_mag = term_g_q[GSW-1] ? MW'(-term_g_q) : MW'(term_g_q);
  assign t_den = DW'(term_h_q) + DW'(lambda_q);
  assign quo_s = $signed({6'b0, quo_q});

  // leaf weight is -G*1.0/(H+lambda), truncated toward zero
  assign w_full = (term_g_q > 0) ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});
  assign w_sat  = (w_full > WMAX) ? 32'sh7FFF_FFFF :
                  (w_full < WMIN) ? 32'sh8000_0000 : 32'(w_full);
  assign gain_sat = (best_gain_q > GMAX) ? 32'sh7FFF_FFFF :
                    (best_gain_q < GMIN) ? 32'sh8000_0000 : 32'(best_gain_q);

  assign sc_w   = go_left_q ? wl_q[cls_q] : wr_q[cls_q];
  assign sc_sum = $signed({sc_rd_q[31], sc_rd_q}) + $signed({sc_w[31], sc_w});
  assign sc_we  = (state_q == ST_CLR) || (state_q == ST_U_SCAP);
  assign sc_wd  = (state_q == ST_CLR) ? 32'sh0 :
                  (sc_sum > 33'sh0_7FFF_FFFF) ? 32'sh7FFF_FFFF :
                  (sc_sum < -33'sh0_8000_0000) ? 32'sh8000_0000 : 32'(sc_sum);

  always_comb begin
    if (state_q == ST_W_SET ? side_q : side_q) begin
      if (state_q == ST_W_SET) begin
        sel_g = tot_g_q[cls_q] - bl_g_q[cls_q];
        sel_h = tot_h_q[cls_q] - bl_h_q[cls_q];
      end else begin
        sel_g = tot_g_q[cls_q] - lg_q[cls_q];
        sel_h = tot_h_q[cls_q] - lh_q[cls_q];
      end
    end else begin
      sel_g = (state_q == ST_W_SET) ? bl_g_q[cls_q] : lg_q[cls_q];
      sel_h = (state_q == ST_W_SET) ? bl_h_q[cls_q] : lh_q[cls_q];
    end
  end

  // stores
  always_ff @(posedge clk_i) begin
    if (in_acc && in_d.operation == bst_pkg::OP_FEATURE && in_si_ok && in_fi_ok) begin
      feat_mem[feat_wa] <= in_d.feature_value;
    end
    feat_rd_q <= feat_mem[feat_ra];
  end

  always_ff @(posedge clk_i) begin
    if (sc_we) begin
      sc_mem[row_a] <= sc_wd;
    end
    sc_rd_q <= sc_mem[row_a];
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_GH) begin
      gh_mem[row_a] <= {grad_val, hess_val};
    end
    gh_rd_q <= gh_mem[row_a];
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && in_d.operation == bst_pkg::OP_LABEL && in_si_ok) begin
      lab_mem[SAMP_W'(in_d.sample_index)] <= in_d.class_label;
    end
    lab_rd_q <= lab_mem[j_q];
  end

  // per-class register files
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        for (int c = 0; c < NUM_CLASS; c++) begin
          tot_g_q[c] <= '0;
          tot_h_q[c] <= '0;
        end
      end
      ST_GA_CAP: s_q[cls_q] <= sc_rd_q;
      ST_EX2:    e_q[cls_q] <= ex_e;
      ST_GH: begin
        tot_g_q[cls_q] <= tot_g_q[cls_q] + GSW'(grad_val);
        tot_h_q[cls_q] <= tot_h_q[cls_q] + MW'(hess_val);
      end
      ST_CT_CAP: begin
        for (int c = 0; c < NUM_CLASS; c++) begin
          lg_q[c] <= '0;
          lh_q[c] <= '0;
        end
      end
      ST_CG_CAP: begin
        lg_q[cls_q] <= lg_q[cls_q] + GSW'(gh_g);
        lh_q[cls_q] <= lh_q[cls_q] + MW'(gh_h);
      end
      ST_CMP: begin
        if (!best_valid_q || gain_q > best_gain_q) begin
          for (int c = 0; c < NUM_CLASS; c++) begin
            bl_g_q[c] <= lg_q[c];
            bl_h_q[c] <= lh_q[c];
          end
        end
      end
      ST_W_ACC: begin
        if (side_q) begin
          wr_q[cls_q] <= w_sat;
        end else begin
          wl_q[cls_q] <= w_sat;
        end
      end
      default: ;
    endcase
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      ret_q        <= ST_IDLE;
      cls_q        <= '0;
      j_q          <= '0;
      i_q          <= '0;
      f_q          <= '0;
      best_f_q     <= '0;
      side_q       <= 1'b0;
      leaf_q       <= 1'b0;
      best_valid_q <= 1'b0;
      go_left_q    <= 1'b0;
      n_q          <= CNT_W'(1);
      nf_q         <= NF_W'(1);
      lambda_q     <= bst_pkg::LAMBDA_RST;
      samples_q    <= bst_pkg::SAMPLES_RST;
      features_q   <= bst_pkg::FEATURES_RST;
      m_q          <= '0;
      thr_q        <= '0;
      best_thr_q   <= '0;
      y_q          <= '0;
      sum_q        <= '0;
      quo_q        <= '0;
      rem_q        <= '0;
      den_q        <= '0;
      dcnt_q       <= '0;
      term_g_q     <= '0;
      term_h_q     <= '0;
      tot_gain_q   <= '0;
      gain_q       <= '0;
      best_gain_q  <= '0;
    end else begin
      if (cfg_acc) begin
        unique case (cfg_d.index)
          bst_pkg::CFG_LAMBDA:   lambda_q   <= cfg_d.value;
          bst_pkg::CFG_SAMPLES:  samples_q  <= cfg_d.value[10:0];
          bst_pkg::CFG_FEATURES: features_q <= cfg_d.value[4:0];
          default: ;
        endcase
      end

      unique case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            cls_q <= '0;
            j_q   <= '0;
            if (in_d.operation == bst_pkg::OP_LABEL && in_si_ok) begin
              j_q     <= SAMP_W'(in_d.sample_index);
              state_q <= ST_CLR;
            end else if (in_d.operation == bst_pkg::OP_ROUND) begin
              n_q          <= n_clamp;
              nf_q         <= nf_clamp;
              best_valid_q <= 1'b0;
              state_q      <= ST_GA_ISS;
            end
          end
        end
        ST_CLR: begin
          cls_q <= cls_q + CLS_W'(1);
          if (cls_last) begin
            cls_q   <= '0;
            state_q <= ST_IDLE;
          end
        end
        ST_GA_ISS: state_q <= ST_GA_CAP;
        ST_GA_CAP: begin
          if (cls_q == '0 || sc_rd_q > m_q) begin
            m_q <= sc_rd_q;
          end
          if (cls_last) begin
            cls_q   <= '0;
            sum_q   <= '0;
            state_q <= ST_EX1;
          end else begin
            cls_q   <= cls_q + CLS_W'(1);
            state_q <= ST_GA_ISS;
          end
        end
        ST_EX1: begin
          y_q     <= ex_prod[49:16];
          state_q <= ST_EX2;
        end
        ST_EX2: begin
          sum_q <= sum_q + SUM_W'(ex_e);
          if (cls_last) begin
            cls_q   <= '0;
            state_q <= ST_PDIV;
          end else begin
            cls_q   <= cls_q + CLS_W'(1);
            state_q <= ST_EX1;
          end
        end
        ST_PDIV: begin
          quo_q   <= NW'({e_q[cls_q], 16'b0});
          den_q   <= DW'(sum_q);
          rem_q   <= '0;
          dcnt_q  <= '0;
          ret_q   <= ST_GH;
          state_q <= ST_DIV;
        end
        ST_DIV: begin
          rem_q  <= div_bit ? DW'(div_sh - {1'b0, den_q}) : DW'(div_sh);
          quo_q  <= {quo_q[NW-2:0], div_bit};
          dcnt_q <= dcnt_q + DC_W'(1);
          if (dcnt_q == DC_W'(NW - 1)) begin
            state_q <= ret_q;
          end
        end
        ST_GH: begin
          if (cls_last) begin
            cls_q <= '0;
            if (j_last) begin
              j_q        <= '0;
              tot_gain_q <= '0;
              state_q    <= ST_TG_SET;
            end else begin
              j_q     <= j_q + SAMP_W'(1);
              state_q <= ST_GA_ISS;
            end
          end else begin
            cls_q   <= cls_q + CLS_W'(1);
            state_q <= ST_PDIV;
          end
        end
        ST_TG_SET: begin
          term_g_q <= tot_g_q[cls_q];
          term_h_q <= tot_h_q[cls_q];
          leaf_q   <= 1'b0;
          ret_q    <= ST_TG_ACC;
          state_q  <= ST_TERM;
        end
        ST_TG_ACC: begin
          tot_gain_q <= tot_gain_q + quo_s;
          if (cls_last) begin
            cls_q   <= '0;
            f_q     <= '0;
            i_q     <= '0;
            state_q <= ST_CT_ISS;
          end else begin
            cls_q   <= cls_q + CLS_W'(1);
            state_q <= ST_TG_SET;
          end
        end
        ST_TERM: begin
          rem_q  <= '0;
          dcnt_q <= '0;
          den_q  <= t_den;
          if (t_den == '0) begin
            quo_q   <= '0;
            state_q <= ret_q;
          end else begin
            quo_q   <= leaf_q ? NW'({t_mag, 16'b0}) : NW'(t_mag * t_mag);
            state_q <= ST_DIV;
          end
        end
        ST_CT_ISS: state_q <= ST_CT_CAP;
        ST_CT_CAP: begin
          thr_q   <= feat_rd_q;
          j_q     <= '0;
          state_q <= ST_CJ_ISS;
        end
        ST_CJ_ISS: state_q <= ST_CJ_CAP;
        ST_CJ_CAP: begin
          if (feat_rd_q <= thr_q) begin
            cls_q   <= '0;
            state_q <= ST_CG_ISS;
          end else if (j_last) begin
            cls_q   <= '0;
            side_q  <= 1'b0;
            gain_q  <= -tot_gain_q;
            state_q <= ST_CS_SET;
          end else begin
            j_q     <= j_q + SAMP_W'(1);
            state_q <= ST_CJ_ISS;
          end
        end
        ST_CG_ISS: state_q <= ST_CG_CAP;
        ST_CG_CAP: begin
          if (!cls_last) begin
            cls_q   <= cls_q + CLS_W'(1);
            state_q <= ST_CG_ISS;
          end else if (j_last) begin
            cls_q   <= '0;
            side_q  <= 1'b0;
            gain_q  <= -tot_gain_q;
            state_q <= ST_CS_SET;
          end else begin
            j_q     <= j_q + SAMP_W'(1);
            state_q <= ST_CJ_ISS;
          end
        end
        ST_CS_SET: begin
          term_g_q <= sel_g;
          term_h_q <= sel_h;
          leaf_q   <= 1'b0;
          ret_q    <= ST_CS_ACC;
          state_q  <= ST_TERM;
        end
        ST_CS_ACC: begin
          gain_q <= gain_q + quo_s;
          side_q <= ~side_q;
          if (!side_q) begin
            state_q <= ST_CS_SET;
          end else if (cls_last) begin
            cls_q   <= '0;
            state_q <= ST_CMP;
          end else begin
            cls_q   <= cls_q + CLS_W'(1);
            state_q <= ST_CS_SET;
          end
        end
        ST_CMP: begin
          // first strictly better candidate wins
          if (!best_valid_q || gain_q > best_gain_q) begin
            best_valid_q <= 1'b1;
            best_f_q     <= f_q;
            best_thr_q   <= thr_q;
            best_gain_q  <= gain_q;
          end
          if (!i_last) begin
            i_q     <= i_q + SAMP_W'(1);
            state_q <= ST_CT_ISS;
          end else begin
            i_q <= '0;
            if (f_last) begin
              cls_q   <= '0;
              side_q  <= 1'b0;
              state_q <= ST_W_SET;
            end else begin
              f_q     <= f_q + FEAT_W'(1);
              state_q <= ST_CT_ISS;
            end
          end
        end
        ST_W_SET: begin
          term_g_q <= sel_g;
          term_h_q <= sel_h;
          leaf_q   <= 1'b1;
          ret_q    <= ST_W_ACC;
          state_q  <= ST_TERM;
        end
        ST_W_ACC: begin
          side_q <= ~side_q;
          if (!side_q) begin
            state_q <= ST_W_SET;
          end else if (cls_last) begin
            cls_q   <= '0;
            j_q     <= '0;
            state_q <= ST_U_FRD;
          end else begin
            cls_q   <= cls_q + CLS_W'(1);
            state_q <= ST_W_SET;
          end
        end
        ST_U_FRD: state_q <= ST_U_FCAP;
        ST_U_FCAP: begin
          go_left_q <= (feat_rd_q <= best_thr_q);
          cls_q     <= '0;
          state_q   <= ST_U_SISS;
        end
        ST_U_SISS: state_q <= ST_U_SCAP;
        ST_U_SCAP: begin
          if (!cls_last) begin
            cls_q   <= cls_q + CLS_W'(1);
            state_q <= ST_U_SISS;
          end else if (j_last) begin
            cls_q   <= '0;
            state_q <= ST_OUT;
          end else begin
            j_q     <= j_q + SAMP_W'(1);
            state_q <= ST_U_FRD;
          end
        end
        ST_OUT: begin
          if (out_o.ready) begin
            if (cls_last) begin
              cls_q   <= '0;
              state_q <= ST_IDLE;
            end else begin
              cls_q <= cls_q + CLS_W'(1);
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_o.valid                  = (state_q == ST_OUT);
  assign out_o.data.class_index       = bst_pkg::CLS_OUT_W'(cls_q);
  assign out_o.data.split_feature     = bst_pkg::FEAT_OUT_W'(best_f_q);
  assign out_o.data.split_threshold   = best_thr_q;
  assign out_o.data.split_gain        = gain_sat;
  assign out_o.data.left_leaf_weight  = wl_q[cls_q];
  assign out_o.data.right_leaf_weight = wr_q[cls_q];
  assign out_o.data.last              = cls_last;

endmodule

/* src/bst_checker.sv */
// Port-level checks for the boosted stump trainer, bound to the top level.
// Uses bst_pkg for operation codes.
module bst_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic [1:0] in_op_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic       out_last_i,
  input logic [2:0] out_cls_i
);

  // a waiting result keeps its class
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_cls_i))
    else $error("result changed while stalled");

  // no new item is taken while results are pending
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(out_valid_i && in_ready_i))
    else $error("input ready while results pending");

  a_round_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && in_op_i == bst_pkg::OP_ROUND |=> !in_ready_i)
    else $error("ready right after a round transfer");

  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i && out_last_i |=> !out_valid_i)
    else $error("result after the last one of a round");

endmodule

bind boosted_stump_trainer bst_checker u_bst_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .in_op_i     (in_i.data.operation),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_last_i  (out_o.data.last),
  .out_cls_i   (out_o.data.class_index)
);

/* bench/boosted_stump_trainer_test.sv */
// Self-checking bench for boosted_stump_trainer: directed and random load/round traffic,
// with an in-bench predictor of the softmax boosting round. Depends on bst_pkg, bst_chan_if.
`timescale 1ns / 1ps
module boosted_stump_trainer_test;
  import bst_pkg::*;

  localparam int NS = 1024;
  localparam int NF = 16;
  localparam int NC = 7;
  localparam int WDOG_LIMIT = 600000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  bst_chan_if #(.payload_t(in_item_t))  in_ch ();
  bst_chan_if #(.payload_t(out_item_t)) out_ch ();
  bst_chan_if #(.payload_t(cfg_item_t)) cfg_ch ();

  boosted_stump_trainer dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch),
    .out_o (out_ch),
    .cfg_i (cfg_ch)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // predictor state
  int          feat_mem [NS*NF];
  bit          feat_set [NS*NF];
  logic [2:0]  label_mem [NS];
  bit          label_set [NS];
  int          score_mem [NS*NC];
  int          grad_mem [NS*NC];
  int          hess_mem [NS*NC];
  logic [31:0] lambda_q;
  logic [10:0] n_samples;
  logic [4:0]  n_feats;
  out_item_t   leaf_q[$];
  int          errors = 0;
  int          idle_cycles = 0;
  int          burst_left = 0;

  const longint frac_tbl[17] = '{65536, 62757, 60097, 57549, 55109, 52773, 50535, 48393,
                                 46341, 44376, 42495, 40693, 38968, 37316, 35734, 34219, 32768};

  function automatic int sat32(longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return int'(v);
  endfunction

  function automatic longint exp_neg(longint unsigned mag);
    longint unsigned y, k;
    int unsigned fr, ti;
    longint lo, a, b, v;
    y = (mag * 64'd94548) >> 16;
    k = y >> 16;
    fr = int'(y & 64'hFFFF);
    ti = fr >> 12;
    lo = longint'(fr & 32'hFFF);
    if (k >= 31) return 0;
    a = frac_tbl[ti];
    b = frac_tbl[ti+1];
    v = a - (((a - b) * lo) >>> 12);
    return v >>> k;
  endfunction

  function automatic longint split_term(longint g, longint h);
    longint d;
    longint unsigned mag;
    d = h + longint'({32'd0, lambda_q});
    mag = (g < 0) ? longint'(-g) : longint'(g);
    if (d <= 0) return 0;
    return longint'((mag * mag) / longint'(d));
  endfunction

  function automatic int leaf_of(longint g, longint h);
    longint d;
    d = h + longint'({32'd0, lambda_q});
    if (d <= 0) return 0;
    return sat32((-g * 65536) / d);
  endfunction

  function automatic void predict_round();
    int n, nf, j, c, f, i, thr, bf, bthr;
    longint tot[14], ls[14], rs[14];
    longint tot_gain, gain, bgain, m, sum, p, y;
    longint e[NC];
    int bwl[NC], bwr[NC];
    bit found, go_left;
    out_item_t r;
    n = (n_samples < 1) ? 1 : ((n_samples > NS) ? NS : int'(n_samples));
    nf = (n_feats < 1) ? 1 : ((n_feats > NF) ? NF : int'(n_feats));
    for (j = 0; j < n; j++) begin
      m = score_mem[j*NC];
      sum = 0;
      for (c = 1; c < NC; c++) if (score_mem[j*NC+c] > m) m = score_mem[j*NC+c];
      for (c = 0; c < NC; c++) begin
        e[c] = exp_neg(longint'(m - longint'(score_mem[j*NC+c])));
        sum += e[c];
      end
      for (c = 0; c < NC; c++) begin
        p = (e[c] * 65536) / sum;
        y = (label_mem[j] == c) ? 65536 : 0;
        grad_mem[j*NC+c] = int'(p - y);
        hess_mem[j*NC+c] = int'((p * (65536 - p)) >>> 16);
      end
    end
    tot = '{default: 0};
    tot_gain = 0;
    for (j = 0; j < n; j++)
      for (c = 0; c < NC; c++) begin
        tot[2*c] += grad_mem[j*NC+c];
        tot[2*c+1] += hess_mem[j*NC+c];
      end
    for (c = 0; c < NC; c++) tot_gain += split_term(tot[2*c], tot[2*c+1]);
    found = 0;
    bf = 0; bthr = 0; bgain = 0;
    for (f = 0; f < nf; f++)
      for (i = 0; i < n; i++) begin
        thr = feat_mem[i*NF+f];
        gain = -tot_gain;
        ls = '{default: 0};
        rs = '{default: 0};
        for (j = 0; j < n; j++)
          for (c = 0; c < NC; c++)
            if (feat_mem[j*NF+f] <= thr) begin
              ls[2*c] += grad_mem[j*NC+c];
              ls[2*c+1] += hess_mem[j*NC+c];
            end else begin
              rs[2*c] += grad_mem[j*NC+c];
              rs[2*c+1] += hess_mem[j*NC+c];
            end
        for (c = 0; c < NC; c++)
          gain += split_term(ls[2*c], ls[2*c+1]) + split_term(rs[2*c], rs[2*c+1]);
        if (!found || gain > bgain) begin
          found = 1;
          bf = f; bthr = thr; bgain = gain;
          for (c = 0; c < NC; c++) begin
            bwl[c] = leaf_of(ls[2*c], ls[2*c+1]);
            bwr[c] = leaf_of(rs[2*c], rs[2*c+1]);
          end
        end
      end
    for (j = 0; j < n; j++) begin
      go_left = feat_mem[j*NF+bf] <= bthr;
      for (c = 0; c < NC; c++)
        score_mem[j*NC+c] = sat32(longint'(score_mem[j*NC+c]) + (go_left ? bwl[c] : bwr[c]));
    end
    for (c = 0; c < NC; c++) begin
      r.class_index = c;
      r.split_feature = bf;
      r.split_threshold = bthr;
      r.split_gain = sat32(bgain);
      r.left_leaf_weight = bwl[c];
      r.right_leaf_weight = bwr[c];
      r.last = (c == NC - 1);
      leaf_q.push_back(r);
    end
  endfunction

  function automatic void apply_item(in_item_t it);
    int c;
    case (it.operation)
      OP_FEATURE: begin
        feat_mem[it.sample_index*NF + it.feature_index] = it.feature_value;
        feat_set[it.sample_index*NF + it.feature_index] = 1;
      end
      OP_LABEL: begin
        label_mem[it.sample_index] = it.class_label;
        label_set[it.sample_index] = 1;
        for (c = 0; c < NC; c++) score_mem[it.sample_index*NC + c] = 0;
      end
      OP_ROUND: predict_round();
      default: ;
    endcase
  endfunction

  // sender: bursts of random length, random gaps between them
  task automatic send_item(in_item_t it);
    if (burst_left == 0) begin
      if ($urandom_range(0, 3) != 0) repeat ($urandom_range(1, 8)) @(negedge clk_i);
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    in_ch.data = it;
    in_ch.valid = 1'b1;
    do @(posedge clk_i); while (!in_ch.ready);
    apply_item(it);
    @(negedge clk_i);
    in_ch.valid = 1'b0;
  endtask

  task automatic send_feature(int si, int fi, int val);
    in_item_t it;
    it = '0;
    it.operation = OP_FEATURE;
    it.sample_index = si;
    it.feature_index = fi;
    it.feature_value = val;
    it.class_label = $urandom;
    send_item(it);
  endtask

  task automatic send_label(int si, int lab);
    in_item_t it;
    it = '0;
    it.operation = OP_LABEL;
    it.sample_index = si;
    it.feature_index = $urandom;
    it.feature_value = $urandom;
    it.class_label = lab;
    send_item(it);
  endtask

  task automatic send_op(logic [1:0] op);
    in_item_t it;
    it = '0;
    it.operation = op;
    it.sample_index = $urandom;
    it.feature_index = $urandom;
    it.feature_value = $urandom;
    it.class_label = $urandom;
    send_item(it);
  endtask

  task automatic wait_results();
    wait (leaf_q.size() == 0);
    @(negedge clk_i);
  endtask

  // label writes leave the block busy clearing a score row after they are taken
  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    wait_results();
    repeat (30) @(negedge clk_i);
    cfg_ch.data.index = idx;
    cfg_ch.data.value = val;
    cfg_ch.valid = 1'b1;
    do @(posedge clk_i); while (!cfg_ch.ready);
    case (idx)
      CFG_LAMBDA:   lambda_q = val;
      CFG_SAMPLES:  n_samples = val[10:0];
      CFG_FEATURES: n_feats = val[4:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_ch.valid = 1'b0;
  endtask

  // every store entry a round will read gets written first
  task automatic fill_round_inputs();
    int n, nf, j, f;
    n = (n_samples < 1) ? 1 : ((n_samples > NS) ? NS : int'(n_samples));
    nf = (n_feats < 1) ? 1 : ((n_feats > NF) ? NF : int'(n_feats));
    for (j = 0; j < n; j++) begin
      if (!label_set[j]) send_label(j, $urandom_range(0, 7));
      for (f = 0; f < nf; f++)
        if (!feat_set[j*NF+f]) send_feature(j, f, $signed($urandom_range(0, 15)) <<< 14);
    end
  endtask

  function automatic int rand_value();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return 32'sh80000000 + $urandom_range(0, 1);
      2: return 32'sh7fffffff - $urandom_range(0, 1);
      default: return ($signed($urandom_range(0, 7)) - 3) <<< 15;
    endcase
  endfunction

  task automatic test_defaults();
    int f;
    send_label(0, 3);
    for (f = 0; f < NF; f++) send_feature(0, f, f <<< 16);
    send_op(OP_ROUND);
    send_op(OP_ROUND);
  endtask

  task automatic test_extremes();
    write_reg(CFG_SAMPLES, 11'd3);
    write_reg(CFG_FEATURES, 5'd2);
    send_label(0, 0);
    send_label(1, 6);
    send_label(2, 7);  // no class is true
    send_feature(0, 0, 32'sh80000000);
    send_feature(1, 0, 32'sh7fffffff);
    send_feature(2, 0, 32'sh7fffffff);  // tie on threshold
    send_feature(0, 1, 0);
    send_feature(1, 1, 0);
    send_feature(2, 1, -1);
    send_op(2'd3);  // unused code, ignored
    send_op(OP_ROUND);
    write_reg(CFG_LAMBDA, 32'd0);
    send_op(OP_ROUND);
    send_op(OP_ROUND);
    write_reg(CFG_LAMBDA, 32'hffffffff);
    send_op(OP_ROUND);
    write_reg(CFG_SAMPLES, 11'd0);
    write_reg(CFG_FEATURES, 5'd0);
    send_op(OP_ROUND);
    write_reg(CFG_SAMPLES, 11'd1024);
    write_reg(CFG_SAMPLES, 11'h7ff);
    write_reg(CFG_SAMPLES, 11'd2);
    write_reg(CFG_FEATURES, 5'd31);
    write_reg(CFG_LAMBDA, 32'h0001_0000);
    fill_round_inputs();
    send_op(OP_ROUND);
  endtask

  task automatic test_random();
    int k, sel, n;
    k = 0;
    while (k < 160) begin
      if (k % 32 == 0) begin
        n = $urandom_range(1, 6);
        write_reg(CFG_SAMPLES, n);
        write_reg(CFG_FEATURES, (n <= 3 && $urandom_range(0, 3) == 0) ? 16 :
                                $urandom_range(1, 4));
        case ($urandom_range(0, 3))
          0: write_reg(CFG_LAMBDA, 32'd0);
          1: write_reg(CFG_LAMBDA, 32'h0001_0000);
          default: write_reg(CFG_LAMBDA, $urandom_range(0, 32'h0004_0000));
        endcase
      end
      sel = $urandom_range(0, 99);
      if (sel < 60) begin
        send_feature(($urandom_range(0, 9) == 0) ? $urandom_range(0, NS-1) :
                     $urandom_range(0, n_samples - 1), $urandom_range(0, NF-1), rand_value());
      end else if (sel < 75) begin
        send_label(($urandom_range(0, 7) == 0) ? $urandom_range(0, NS-1) :
                   $urandom_range(0, n_samples - 1), $urandom_range(0, 7));
      end else if (sel < 80) begin
        send_op(2'd3);
      end else begin
        fill_round_inputs();
        send_op(OP_ROUND);
        if ($urandom_range(0, 2) == 0) wait_results();  // sender holds off until drained
      end
      k++;
    end
  endtask

  // receiver: ready follows modes of random length
  initial begin
    int seg, mode;
    out_ch.ready = 1'b0;
    seg = 0;
    mode = 0;
    forever begin
      @(negedge clk_i);
      if (seg == 0) begin
        seg = $urandom_range(5, 40);
        mode = $urandom_range(0, 2);
      end
      seg--;
      case (mode)
        0: out_ch.ready = 1'b1;
        1: out_ch.ready = $urandom_range(0, 1);
        default: out_ch.ready = (seg % 7 == 0);
      endcase
    end
  end

  function automatic void check_field(string name, longint exp_v, longint act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $realtime, name, exp_v, act_v);
      errors++;
    end
  endfunction

  always @(posedge clk_i) begin
    out_item_t ex, ac;
    if (out_ch.valid && out_ch.ready) begin
      ac = out_ch.data;
      if (leaf_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, got class %0d", $realtime,
                 ac.class_index);
        errors++;
      end else begin
        ex = leaf_q.pop_front();
        check_field("class_index", ex.class_index, ac.class_index);
        check_field("split_feature", ex.split_feature, ac.split_feature);
        check_field("split_threshold", ex.split_threshold, ac.split_threshold);
        check_field("split_gain", ex.split_gain, ac.split_gain);
        check_field("left_leaf_weight", ex.left_leaf_weight, ac.left_leaf_weight);
        check_field("right_leaf_weight", ex.right_leaf_weight, ac.right_leaf_weight);
        check_field("last", ex.last, ac.last);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WDOG_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = '0;
    lambda_q = LAMBDA_RST;
    n_samples = SAMPLES_RST;
    n_feats = FEATURES_RST;
    score_mem = '{default: 0};
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_defaults();
    test_extremes();
    test_random();
    wait_results();
    repeat (50) @(negedge clk_i);
    if (errors == 0 && leaf_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
